/* hdl/bone_world_transform_compose_macros.svh */
// Assertion macros for the bone world transform composer.
`ifndef BONE_WORLD_TRANSFORM_COMPOSE_MACROS_SVH
`define BONE_WORLD_TRANSFORM_COMPOSE_MACROS_SVH
`ifndef SYNTH
`define BWTC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define BWTC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BWTC_ASSERT_IMP(label, clk, rst_n, a, c)
`define BWTC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* hdl/bwtc_pkg.sv */
// ----------------------------------------------------------------------------
// bwtc_pkg
// Types and constants shared by the bone world transform composer.
// ----------------------------------------------------------------------------
`default_nettype none
package bwtc_pkg;
    localparam logic signed [15:0] Q_ONE = 16'sd16384;
    localparam logic signed [15:0] S_ONE = 16'sd256;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] rw;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
    } xform_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // Round half up by s bits, then keep the low 33 bits of the result.
    function automatic logic signed [32:0] rnd_shift(input logic signed [79:0] v,
                                                    input int s);
        logic signed [79:0] t;
        begin
            t = (v + (80'sd1 <<< (s - 1))) >>> s;
            rnd_shift = t[32:0];
        end
    endfunction

    function automatic logic signed [79:0] rnd_wide(input logic signed [79:0] v,
                                                   input int s);
        begin
            rnd_wide = (v + (80'sd1 <<< (s - 1))) >>> s;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [79:0] v);
        begin
            if (v > 80'sd32767)
                sat16 = 16'sh7fff;
            else if (v < -80'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = v[15:0];
        end
    endfunction

    function automatic logic ovf16(input logic signed [79:0] v);
        begin
            ovf16 = (v > 80'sd32767) || (v < -80'sd32768);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        begin
            if (v > 80'sd2147483647)
                sat32 = 32'sh7fffffff;
            else if (v < -80'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    function automatic logic ovf32(input logic signed [79:0] v);
        begin
            ovf32 = (v > 80'sd2147483647) || (v < -80'sd2147483648);
        end
    endfunction
endpackage
`default_nettype wire

/* hdl/bone_world_transform_compose.sv */
// ----------------------------------------------------------------------------
// bone_world_transform_compose
// Forward kinematics: composes each bone's local transform with its parent's
// stored world transform and writes the result back to the world table.
// ----------------------------------------------------------------------------
// Usage: raise start with one bone's local transform while busy is low; the
// word is taken at that edge. Bones come in index order; an internal counter
// assigns the index and wraps at bone_count. bone_count is written on the
// cfg channel (cfg_valid/cfg_ready); a write also clears the counter.
// The table read of the parent is issued at the edge that takes the word.
// The result then passes four steps: READ takes the quaternion, scale and
// scaled position products, MUL1 the first cross product, MUL2 the second
// cross product and saturation, and in OUT the result sits in the output
// register and is strobed. busy stays high until the strobe has passed, so
// a new word is taken only after the last one is through. The dependency
// on the parent, usually the previous bone, sets this.
// The result sits on the result ports for one cycle with result_valid high;
// the receiver cannot stall. After reset the table reads as identity for
// every entry (valid bits, no clearing pass), bone_count is 1 and the
// counter is 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bone_world_transform_compose_macros.svh"
module bone_world_transform_compose #(
    parameter int MAX_BONES = 256
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire  [8:0]        cfg_data,
    input  wire               start,
    output logic              busy,
    input  wire               has_parent,
    input  wire  [7:0]        parent_index,
    input  wire signed [31:0] local_pos_x,
    input  wire signed [31:0] local_pos_y,
    input  wire signed [31:0] local_pos_z,
    input  wire signed [15:0] local_rot_w,
    input  wire signed [15:0] local_rot_x,
    input  wire signed [15:0] local_rot_y,
    input  wire signed [15:0] local_rot_z,
    input  wire signed [15:0] local_scale_x,
    input  wire signed [15:0] local_scale_y,
    input  wire signed [15:0] local_scale_z,
    output logic              result_valid,
    output logic [7:0]        bone_index,
    output logic signed [31:0] world_pos_x,
    output logic signed [31:0] world_pos_y,
    output logic signed [31:0] world_pos_z,
    output logic signed [15:0] world_rot_w,
    output logic signed [15:0] world_rot_x,
    output logic signed [15:0] world_rot_y,
    output logic signed [15:0] world_rot_z,
    output logic signed [15:0] world_scale_x,
    output logic signed [15:0] world_scale_y,
    output logic signed [15:0] world_scale_z,
    output logic              overflow
);
    import bwtc_pkg::*;

    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int CW = AW + 1;

    state_t state_reg, state_next;
    logic [8:0]    count_reg;
    logic [CW-1:0] counter_reg;
    logic [CW-1:0] cnt_eff, idx, idx_inc;
    logic [CW-1:0] idx_reg;
    xform_t  loc_reg, par, res_reg;
    xform_t  tbl_q;
    logic    has_par_reg, par_ok_reg, ov_reg;
    logic    rd_en, wr_en;
    logic [AW-1:0] rd_addr;

    // Stage registers.
    logic signed [79:0] wr_q_reg [4];
    logic signed [79:0] ws_q_reg [3];
    logic signed [79:0] v_reg [3];
    logic signed [79:0] t_reg [3];
    logic signed [15:0] u_reg [3];
    logic signed [15:0] w_reg;
    logic signed [31:0] pp_reg [3];

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        if (count_reg == 9'd0)
            cnt_eff = CW'(1);
        else if (32'(count_reg) > MAX_BONES)
            cnt_eff = CW'(MAX_BONES);
        else
            cnt_eff = CW'(count_reg);
        idx     = (counter_reg < cnt_eff) ? counter_reg : '0;
        idx_inc = idx + CW'(1);
        rd_en   = start && !busy && has_parent && (32'(parent_index) < MAX_BONES);
        rd_addr = AW'(parent_index);
        par     = '0;
        par.rw  = Q_ONE;
        par.sx  = S_ONE;
        par.sy  = S_ONE;
        par.sz  = S_ONE;
        if (par_ok_reg)
            par = tbl_q;
        wr_en   = (state_reg == ST_OUT) && (32'(idx_reg) < MAX_BONES);
    end

    bwtc_table #(.DEPTH(MAX_BONES), .AW(AW)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (tbl_q),
        .wr_en   (wr_en),
        .wr_addr (AW'(idx_reg)),
        .wr_data (res_reg)
    );

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = (start) ? ST_READ : ST_IDLE;
            ST_READ: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= 9'd1;
            counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg   <= cfg_data;
                counter_reg <= '0;
            end
            else if (start && !busy)
                counter_reg <= (idx_inc >= cnt_eff) ? '0 : idx_inc;
        end
    end

    // Capture the local word.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            idx_reg     <= idx;
            has_par_reg <= has_parent;
            par_ok_reg  <= rd_en;
            loc_reg     <= '{local_pos_x, local_pos_y, local_pos_z,
                             local_rot_w, local_rot_x, local_rot_y, local_rot_z,
                             local_scale_x, local_scale_y, local_scale_z};
        end
    end

    // First multiply stage: quaternion product, scales, scaled position.
    logic signed [79:0] pr [4];
    logic signed [79:0] lr [4];
    logic signed [79:0] ps [3];
    logic signed [79:0] ls [3];
    logic signed [79:0] lp [3];
    always_comb
    begin
        pr[0] = 80'(par.rw); pr[1] = 80'(par.rx);
        pr[2] = 80'(par.ry); pr[3] = 80'(par.rz);
        lr[0] = 80'(loc_reg.rw); lr[1] = 80'(loc_reg.rx);
        lr[2] = 80'(loc_reg.ry); lr[3] = 80'(loc_reg.rz);
        ps[0] = 80'(par.sx); ps[1] = 80'(par.sy); ps[2] = 80'(par.sz);
        ls[0] = 80'(loc_reg.sx); ls[1] = 80'(loc_reg.sy); ls[2] = 80'(loc_reg.sz);
        lp[0] = 80'(loc_reg.px); lp[1] = 80'(loc_reg.py); lp[2] = 80'(loc_reg.pz);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            wr_q_reg[0] <= pr[0]*lr[0] - pr[1]*lr[1] - pr[2]*lr[2] - pr[3]*lr[3];
            wr_q_reg[1] <= pr[0]*lr[1] + pr[1]*lr[0] + pr[2]*lr[3] - pr[3]*lr[2];
            wr_q_reg[2] <= pr[0]*lr[2] - pr[1]*lr[3] + pr[2]*lr[0] + pr[3]*lr[1];
            wr_q_reg[3] <= pr[0]*lr[3] + pr[1]*lr[2] - pr[2]*lr[1] + pr[3]*lr[0];
            for (int i = 0; i < 3; i++)
            begin
                ws_q_reg[i] <= ps[i] * ls[i];
                v_reg[i]    <= rnd_wide(ps[i] * lp[i], 8);
                u_reg[i]    <= pr[i+1][15:0];
            end
            w_reg     <= par.rw;
            pp_reg[0] <= par.px;
            pp_reg[1] <= par.py;
            pp_reg[2] <= par.pz;
        end
        else if (state_reg == ST_MUL1)
        begin
            // t = 2 * (u x v) in position units.
            t_reg[0] <= rnd_wide(80'(u_reg[1])*v_reg[2] - 80'(u_reg[2])*v_reg[1], 13);
            t_reg[1] <= rnd_wide(80'(u_reg[2])*v_reg[0] - 80'(u_reg[0])*v_reg[2], 13);
            t_reg[2] <= rnd_wide(80'(u_reg[0])*v_reg[1] - 80'(u_reg[1])*v_reg[0], 13);
        end
    end

    // Second stage: finish the rotated vector and saturate everything.
    logic signed [79:0] ut [3];
    logic signed [79:0] pos [3];
    logic signed [79:0] rq [4];
    logic signed [79:0] sq [3];
    xform_t comp;
    logic   comp_ov;
    always_comb
    begin
        ut[0] = 80'(u_reg[1])*t_reg[2] - 80'(u_reg[2])*t_reg[1];
        ut[1] = 80'(u_reg[2])*t_reg[0] - 80'(u_reg[0])*t_reg[2];
        ut[2] = 80'(u_reg[0])*t_reg[1] - 80'(u_reg[1])*t_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = 80'(pp_reg[i]) + v_reg[i] + rnd_wide(80'(w_reg) * t_reg[i], 14)
                     + rnd_wide(ut[i], 14);
            sq[i]  = rnd_wide(ws_q_reg[i], 8);
        end
        for (int i = 0; i < 4; i++)
            rq[i] = rnd_wide(wr_q_reg[i], 14);
        comp = '{sat32(pos[0]), sat32(pos[1]), sat32(pos[2]),
                 sat16(rq[0]), sat16(rq[1]), sat16(rq[2]), sat16(rq[3]),
                 sat16(sq[0]), sat16(sq[1]), sat16(sq[2])};
        comp_ov = ovf32(pos[0]) | ovf32(pos[1]) | ovf32(pos[2])
                | ovf16(rq[0]) | ovf16(rq[1]) | ovf16(rq[2]) | ovf16(rq[3])
                | ovf16(sq[0]) | ovf16(sq[1]) | ovf16(sq[2]);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL2)
        begin
            res_reg <= has_par_reg ? comp : loc_reg;
            ov_reg  <= has_par_reg & comp_ov;
        end
    end

    always_comb
    begin
        result_valid  = (state_reg == ST_OUT);
        bone_index    = 8'(idx_reg);
        world_pos_x   = res_reg.px;
        world_pos_y   = res_reg.py;
        world_pos_z   = res_reg.pz;
        world_rot_w   = res_reg.rw;
        world_rot_x   = res_reg.rx;
        world_rot_y   = res_reg.ry;
        world_rot_z   = res_reg.rz;
        world_scale_x = res_reg.sx;
        world_scale_y = res_reg.sy;
        world_scale_z = res_reg.sz;
        overflow      = ov_reg;
    end

    `BWTC_ASSERT_NEXT(a_start_runs, clk, rst_n, start && !busy, state_reg == ST_READ)
    `BWTC_ASSERT_NEXT(a_out_one, clk, rst_n, result_valid, !result_valid)
    `BWTC_ASSERT_IMP(a_idx_range, clk, rst_n, result_valid, idx_reg < cnt_eff)
    `BWTC_ASSERT_IMP(a_no_cfg_busy, clk, rst_n, busy, !cfg_ready)
endmodule
`default_nettype wire

/* hdl/bwtc_table.sv */
// ----------------------------------------------------------------------------
// bwtc_table
// World transform store: one synchronous memory, one write and one read port,
// registered read data. Entries not yet written since reset read as identity.
// ----------------------------------------------------------------------------
`default_nettype none
module bwtc_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   rd_en,
    input  wire [AW-1:0]          rd_addr,
    output bwtc_pkg::xform_t      rd_data,
    input  wire                   wr_en,
    input  wire [AW-1:0]          wr_addr,
    input  wire bwtc_pkg::xform_t wr_data
);
    import bwtc_pkg::*;

    xform_t     mem [DEPTH];
    xform_t     q_reg;
    logic       vq_reg;
    logic [DEPTH-1:0] valid_reg;
    xform_t     ident;

    always_comb
    begin
        ident    = '0;
        ident.rw = Q_ONE;
        ident.sx = S_ONE;
        ident.sy = S_ONE;
        ident.sz = S_ONE;
        rd_data  = vq_reg ? q_reg : ident;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            if (rd_en)
                vq_reg <= valid_reg[rd_addr];
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

/* tb/sv/tb_bone_world_transform_compose.sv */
// ----------------------------------------------------------------------------
// tb_bone_world_transform_compose
// Self-checking bench for the bone world transform composer. Bone words go in
// through the start/busy handshake while a scoreboard model composes each
// bone with its parent's stored world transform. Every strobed result is
// compared field by field with the oldest predicted transform. The bone count
// is rewritten between phases, and each phase uses its own sender idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_bone_world_transform_compose;
    timeunit 1ns;
    timeprecision 1ps;

    import bwtc_pkg::*;

    localparam int NBONES = 256;
    localparam int SETTLE = 20;

    typedef struct {
        logic        has_parent;
        logic [7:0]  parent_index;
        xform_t      lx;
        logic        cfg_write;     // a bone count write instead of a bone
        logic [8:0]  cfg_value;
        int          idle_pct;
        logic        drain;         // wait until every result has come
    } bone_word_t;

    typedef struct {
        logic [7:0] idx;
        xform_t     wx;
        logic       ovf;
    } world_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [8:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic has_parent = 1'b0;
    logic [7:0] parent_index = '0;
    logic signed [31:0] local_pos_x = '0, local_pos_y = '0, local_pos_z = '0;
    logic signed [15:0] local_rot_w = '0, local_rot_x = '0, local_rot_y = '0,
                        local_rot_z = '0;
    logic signed [15:0] local_scale_x = '0, local_scale_y = '0, local_scale_z = '0;
    logic result_valid;
    logic [7:0] bone_index;
    logic signed [31:0] world_pos_x, world_pos_y, world_pos_z;
    logic signed [15:0] world_rot_w, world_rot_x, world_rot_y, world_rot_z;
    logic signed [15:0] world_scale_x, world_scale_y, world_scale_z;
    logic overflow;

    bone_world_transform_compose u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .has_parent(has_parent), .parent_index(parent_index),
        .local_pos_x(local_pos_x), .local_pos_y(local_pos_y),
        .local_pos_z(local_pos_z),
        .local_rot_w(local_rot_w), .local_rot_x(local_rot_x),
        .local_rot_y(local_rot_y), .local_rot_z(local_rot_z),
        .local_scale_x(local_scale_x), .local_scale_y(local_scale_y),
        .local_scale_z(local_scale_z),
        .result_valid(result_valid), .bone_index(bone_index),
        .world_pos_x(world_pos_x), .world_pos_y(world_pos_y),
        .world_pos_z(world_pos_z),
        .world_rot_w(world_rot_w), .world_rot_x(world_rot_x),
        .world_rot_y(world_rot_y), .world_rot_z(world_rot_z),
        .world_scale_x(world_scale_x), .world_scale_y(world_scale_y),
        .world_scale_z(world_scale_z),
        .overflow(overflow)
    );

    always #4 clk = ~clk;

    bone_word_t  pending_bones[$];
    world_word_t expected_world[$];
    xform_t      world_table[NBONES];
    logic [8:0]  bone_count_reg;
    int          bone_ctr;
    int          errors = 0;
    int          results_seen = 0;
    int          roots_sent = 0, children_sent = 0, ovf_seen = 0;
    logic        stim_done = 1'b0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, ref logic ov);
        if (v < lo) begin ov = 1'b1; return lo; end
        if (v > hi) begin ov = 1'b1; return hi; end
        return v;
    endfunction

    // Composes one bone with its parent and records it in the world table.
    function automatic world_word_t compose_bone(bone_word_t b);
        world_word_t r;
        int cnt, idx;
        longint lp[3], lr[4], ls[3], pp[3], pr[4], ps[3];
        longint wp[3], wr[4], ws[3], u[3], v[3], c[3], t[3], ut[3];
        logic ov;
        xform_t p;
        ov = 1'b0;
        cnt = bone_count_reg;
        if (cnt == 0) cnt = 1;
        if (cnt > NBONES) cnt = NBONES;
        idx = (bone_ctr < cnt) ? bone_ctr : 0;
        bone_ctr = (idx + 1 >= cnt) ? 0 : idx + 1;
        lp = '{b.lx.px, b.lx.py, b.lx.pz};
        lr = '{b.lx.rw, b.lx.rx, b.lx.ry, b.lx.rz};
        ls = '{b.lx.sx, b.lx.sy, b.lx.sz};
        if (!b.has_parent) begin
            wp = lp; wr = lr; ws = ls;
        end else begin
            p = world_table[b.parent_index];
            pp = '{p.px, p.py, p.pz};
            pr = '{p.rw, p.rx, p.ry, p.rz};
            ps = '{p.sx, p.sy, p.sz};
            wr[0] = pr[0]*lr[0] - pr[1]*lr[1] - pr[2]*lr[2] - pr[3]*lr[3];
            wr[1] = pr[0]*lr[1] + pr[1]*lr[0] + pr[2]*lr[3] - pr[3]*lr[2];
            wr[2] = pr[0]*lr[2] - pr[1]*lr[3] + pr[2]*lr[0] + pr[3]*lr[1];
            wr[3] = pr[0]*lr[3] + pr[1]*lr[2] - pr[2]*lr[1] + pr[3]*lr[0];
            for (int i = 0; i < 4; i++)
                wr[i] = clamp(round_shift(wr[i], 14), -32768, 32767, ov);
            for (int i = 0; i < 3; i++)
                ws[i] = clamp(round_shift(ps[i] * ls[i], 8), -32768, 32767, ov);
            for (int i = 0; i < 3; i++) begin
                u[i] = pr[1 + i];
                v[i] = round_shift(ps[i] * lp[i], 8);
            end
            c[0] = u[1]*v[2] - u[2]*v[1];
            c[1] = u[2]*v[0] - u[0]*v[2];
            c[2] = u[0]*v[1] - u[1]*v[0];
            for (int i = 0; i < 3; i++) t[i] = round_shift(c[i], 13);
            ut[0] = u[1]*t[2] - u[2]*t[1];
            ut[1] = u[2]*t[0] - u[0]*t[2];
            ut[2] = u[0]*t[1] - u[1]*t[0];
            for (int i = 0; i < 3; i++)
                wp[i] = clamp(pp[i] + v[i] + round_shift(pr[0] * t[i], 14)
                              + round_shift(ut[i], 14),
                              -64'sd2147483648, 64'sd2147483647, ov);
        end
        r.idx = idx[7:0];
        r.wx.px = 32'(wp[0]); r.wx.py = 32'(wp[1]); r.wx.pz = 32'(wp[2]);
        r.wx.rw = 16'(wr[0]); r.wx.rx = 16'(wr[1]);
        r.wx.ry = 16'(wr[2]); r.wx.rz = 16'(wr[3]);
        r.wx.sx = 16'(ws[0]); r.wx.sy = 16'(ws[1]); r.wx.sz = 16'(ws[2]);
        r.ovf = ov;
        world_table[idx] = r.wx;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Driver.
    bone_word_t cur;
    logic       cur_loaded = 1'b0;
    int         hold_off = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
                cur_loaded = 1'b0;
            end
            if (start && !busy) begin
                expected_world.insert(expected_world.size(), compose_bone(cur));
                if (cur.has_parent) children_sent++; else roots_sent++;
                cur_loaded = 1'b0;
            end
            if (!cur_loaded && pending_bones.size() > 0) begin
                cur = pending_bones.pop_front();
                cur_loaded = 1'b1;
                hold_off = SETTLE;
            end
            if (!cur_loaded) begin
                start <= 1'b0;
                if (pending_bones.size() == 0) stim_done <= 1'b1;
            end else if (cur.cfg_write || cur.drain) begin
                start <= 1'b0;
                // Idle block: nothing expected and the pipeline settled.
                if (expected_world.size() == 0 && !busy && !start) begin
                    if (hold_off > 0) hold_off--;
                    else if (cur.drain) cur_loaded = 1'b0;
                    else if (!cfg_valid) begin
                        cfg_valid <= 1'b1;
                        cfg_data <= cur.cfg_value;
                        bone_count_reg = cur.cfg_value;
                        bone_ctr = 0;
                    end
                end
            end else if ($urandom_range(99) < cur.idle_pct) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                has_parent <= cur.has_parent;
                parent_index <= cur.parent_index;
                local_pos_x <= cur.lx.px; local_pos_y <= cur.lx.py;
                local_pos_z <= cur.lx.pz;
                local_rot_w <= cur.lx.rw; local_rot_x <= cur.lx.rx;
                local_rot_y <= cur.lx.ry; local_rot_z <= cur.lx.rz;
                local_scale_x <= cur.lx.sx; local_scale_y <= cur.lx.sy;
                local_scale_z <= cur.lx.sz;
            end
        end
    end

    // Monitor.
    always @(posedge clk) begin
        world_word_t e;
        if (rst_n && result_valid) begin
            results_seen++;
            if (overflow) ovf_seen++;
            if (expected_world.size() == 0) begin
                report_mismatch("unexpected result, bone_index", bone_index, -1);
            end else begin
                e = expected_world.pop_front();
                if (bone_index !== e.idx) report_mismatch("bone_index", bone_index, e.idx);
                if (world_pos_x !== e.wx.px) report_mismatch("pos_x", world_pos_x, e.wx.px);
                if (world_pos_y !== e.wx.py) report_mismatch("pos_y", world_pos_y, e.wx.py);
                if (world_pos_z !== e.wx.pz) report_mismatch("pos_z", world_pos_z, e.wx.pz);
                if (world_rot_w !== e.wx.rw) report_mismatch("rot_w", world_rot_w, e.wx.rw);
                if (world_rot_x !== e.wx.rx) report_mismatch("rot_x", world_rot_x, e.wx.rx);
                if (world_rot_y !== e.wx.ry) report_mismatch("rot_y", world_rot_y, e.wx.ry);
                if (world_rot_z !== e.wx.rz) report_mismatch("rot_z", world_rot_z, e.wx.rz);
                if (world_scale_x !== e.wx.sx)
                    report_mismatch("scale_x", world_scale_x, e.wx.sx);
                if (world_scale_y !== e.wx.sy)
                    report_mismatch("scale_y", world_scale_y, e.wx.sy);
                if (world_scale_z !== e.wx.sz)
                    report_mismatch("scale_z", world_scale_z, e.wx.sz);
                if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
            end
        end
    end

    function automatic xform_t rand_xform(int mode);
        xform_t x;
        x.px = $urandom; x.py = $urandom; x.pz = $urandom;
        x.rw = 16'($urandom); x.rx = 16'($urandom);
        x.ry = 16'($urandom); x.rz = 16'($urandom);
        x.sx = 16'($urandom); x.sy = 16'($urandom); x.sz = 16'($urandom);
        if (mode != 0) begin
            // Plausible values: moderate positions, near-unit rotations, small scales.
            x.px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            x.py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            x.pz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            x.rw = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.rx = 16'($signed($urandom_range(0, 23000)) - 11500);
            x.ry = 16'($signed($urandom_range(0, 23000)) - 11500);
            x.rz = 16'($signed($urandom_range(0, 23000)) - 11500);
            x.sx = 16'($urandom_range(64, 1024));
            x.sy = 16'($urandom_range(64, 1024));
            x.sz = 16'($urandom_range(64, 1024));
        end
        return x;
    endfunction

    task automatic add_bone(logic hp, logic [7:0] pi, xform_t x, int idle);
        bone_word_t b;
        b = '{default: '0};
        b.has_parent = hp; b.parent_index = pi; b.lx = x; b.idle_pct = idle;
        pending_bones.insert(pending_bones.size(), b);
    endtask

    task automatic add_count_write(logic [8:0] v);
        bone_word_t b;
        b = '{default: '0};
        b.cfg_write = 1'b1; b.cfg_value = v;
        pending_bones.insert(pending_bones.size(), b);
    endtask

    task automatic add_drain();
        bone_word_t b;
        b = '{default: '0};
        b.drain = 1'b1;
        pending_bones.insert(pending_bones.size(), b);
    endtask

    task automatic add_pose_phase(logic [8:0] count, int nbones, int idle);
        int limit;
        logic [7:0] pi;
        add_count_write(count);
        limit = (count == 0) ? 1 : (count > NBONES ? NBONES : count);
        for (int i = 0; i < nbones; i++) begin
            int r, k;
            r = $urandom_range(99);
            k = i % limit;
            if (r < 8) pi = 8'($urandom);      // any entry of the table
            else pi = (k == 0) ? 8'd0
                               : 8'(k - 1 - int'($urandom_range(0, (k > 3) ? 3 : k - 1)));
            add_bone(!(k == 0 || r < 12 || r == 50), pi, rand_xform(r < 10 ? 0 : 1), idle);
        end
    endtask

    initial begin
        xform_t x;
        bone_count_reg = 9'd1;
        bone_ctr = 0;
        for (int i = 0; i < NBONES; i++)
            world_table[i] = '{0, 0, 0, Q_ONE, 0, 0, 0, S_ONE, S_ONE, S_ONE};

        // Directed: parent reads identity after reset, then extremes.
        add_bone(1'b1, 8'd0, rand_xform(1), 0);
        add_count_write(9'd4);
        x = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        add_bone(1'b0, 8'hff, x, 0);
        add_bone(1'b1, 8'd0, x, 0);
        x = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        add_bone(1'b1, 8'd1, x, 0);
        add_bone(1'b1, 8'd2, x, 0);
        // Bone whose parent was never written in this pose.
        add_bone(1'b1, 8'd200, rand_xform(1), 0);
        // A bone count of zero acts as one.
        add_count_write(9'd0);
        add_bone(1'b1, 8'd0, rand_xform(1), 0);
        add_bone(1'b1, 8'd0, rand_xform(0), 0);
        add_count_write(9'h1ff);
        for (int i = 0; i < 8; i++) add_bone(i != 0, i[7:0], rand_xform(i & 1), 0);
        add_count_write(9'd3);
        add_bone(1'b1, 8'd5, rand_xform(0), 0);

        // Random poses over several bone counts and idling phases.
        add_pose_phase(9'd256, 400, 0);
        add_pose_phase(9'd17, 400, 77);
        add_drain();
        add_pose_phase(9'd1, 100, 0);
        add_pose_phase(9'd300, 400, 12);
        add_pose_phase(9'd2, 100, 77);
        add_pose_phase(9'd64, 500, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_done && expected_world.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d root and %0d child bones, %0d saturated results,",
                 roots_sent, children_sent, ovf_seen);
        $display("bone counts 0, 1, 2, 3, 4, 17, 64, 256, 300 and 511.");
        if (errors == 0 && expected_world.size() == 0)
            $display("bone_world_transform_compose verification clean");
        else
            $display("bone_world_transform_compose verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("bone_world_transform_compose verification failed");
        $finish;
    end
endmodule
`default_nettype wire
